### rtl/core/scl_pkg.sv
package scl_pkg;

   // Character codes the front end recognizes
   localparam logic [7:0] CHAR_EQUALS = 8'h3D;   // '='
   localparam logic [7:0] CHAR_CR     = 8'h0D;   // carriage return
   localparam logic [7:0] CHAR_C      = 8'h43;   // 'C'
   localparam logic [7:0] CHAR_P      = 8'h50;   // 'P'
   localparam logic [7:0] CHAR_D      = 8'h44;   // 'D'
   localparam logic [7:0] CHAR_ZERO   = 8'h30;   // '0'
   localparam logic [7:0] CHAR_COLON  = 8'h3A;   // ':'
   localparam logic [7:0] CHAR_TICK   = 8'h60;   // '`'
   localparam logic [7:0] CHAR_G      = 8'h67;   // 'g'

   // Offset from the low nibble of 'a'..'f' to its hex value
   localparam logic [3:0] LETTER_NIBBLE_OFFSET = 4'd9;
   // Offset from the low nibble of '1'..'9' to the register index
   localparam logic [3:0] DIGIT_INDEX_OFFSET   = 4'd1;

   localparam int CHAR_W  = 8;
   localparam int INDEX_W = 4;
   localparam int VALUE_W = 8;
   localparam int NIB_W   = 4;

   // Keep the depth a power of two so the pointers wrap on their own
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [2:0] {
      CL_EQUALS = 3'd0,
      CL_CR     = 3'd1,
      CL_C      = 3'd2,
      CL_P      = 3'd3,
      CL_D      = 3'd4,
      CL_DIGIT  = 3'd5,
      CL_HEX    = 3'd6,
      CL_OTHER  = 3'd7
   } class_type;

   typedef enum logic [7:0] {
      ST_CMD     = 8'b0000_0001,
      ST_REGNUM  = 8'b0000_0010,
      ST_EQUALS  = 8'b0000_0100,
      ST_UPPER   = 8'b0000_1000,
      ST_LOWER   = 8'b0001_0000,
      ST_CR_REG  = 8'b0010_0000,
      ST_CR_PAGE = 8'b0100_0000,
      ST_CR_UPD  = 8'b1000_0000
   } state_type;

   // One classified character as it travels from front to back
   typedef struct packed {
      class_type          cls;
      logic [NIB_W-1:0]   nibble;
      logic [INDEX_W-1:0] index;
   } entry_type;

endpackage

### rtl/core/scl_if.sv
interface scl_req_if;
   logic                     valid;
   logic                     ready;
   logic [scl_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface scl_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        reg_write;
   logic [scl_pkg::INDEX_W-1:0] reg_index;
   logic [scl_pkg::VALUE_W-1:0] reg_value;
   logic                        page_select;
   logic                        updates_on;
   logic                        command_error;

   modport source (output valid, output reg_write, output reg_index, output reg_value,
                   output page_select, output updates_on, output command_error,
                   input ready);
   modport sink   (input valid, input reg_write, input reg_index, input reg_value,
                   input page_select, input updates_on, input command_error,
                   output ready);
endinterface

### rtl/core/scl_classify.sv
module scl_classify (
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [scl_pkg::CHAR_W-1:0]   in_char,
   output logic                         push_valid,
   input  logic                         push_ready,
   output scl_pkg::entry_type           push_entry
);

   scl_pkg::class_type cls;
   logic               is_decimal;

   always_comb begin
      if (in_char == scl_pkg::CHAR_EQUALS)      cls = scl_pkg::CL_EQUALS;
      else if (in_char == scl_pkg::CHAR_CR)     cls = scl_pkg::CL_CR;
      else if (in_char == scl_pkg::CHAR_C)      cls = scl_pkg::CL_C;
      else if (in_char == scl_pkg::CHAR_P)      cls = scl_pkg::CL_P;
      else if (in_char == scl_pkg::CHAR_D)      cls = scl_pkg::CL_D;
      else if (in_char > scl_pkg::CHAR_ZERO && in_char < scl_pkg::CHAR_COLON)
         cls = scl_pkg::CL_DIGIT;
      else if ((in_char > scl_pkg::CHAR_TICK && in_char < scl_pkg::CHAR_G) ||
               in_char == scl_pkg::CHAR_ZERO)
         cls = scl_pkg::CL_HEX;
      else
         cls = scl_pkg::CL_OTHER;
   end

   // '0'..'9' carry their value in the low nibble; 'a'..'f' need an offset
   assign is_decimal = (in_char >= scl_pkg::CHAR_ZERO) && (in_char < scl_pkg::CHAR_COLON);

   always_comb begin
      push_entry.cls    = cls;
      push_entry.nibble = is_decimal ? in_char[3:0]
                                     : in_char[3:0] + scl_pkg::LETTER_NIBBLE_OFFSET;
      push_entry.index  = in_char[3:0] - scl_pkg::DIGIT_INDEX_OFFSET;
   end

   assign push_valid = in_valid;
   assign in_ready   = push_ready;

endmodule

### rtl/core/scl_queue.sv
module scl_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  scl_pkg::entry_type push_entry,
   output logic               pop_valid,
   input  logic               pop_ready,
   output scl_pkg::entry_type pop_entry
);

   scl_pkg::entry_type               slot_ff [scl_pkg::QUEUE_DEPTH];
   logic [scl_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [scl_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [scl_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic                             do_push, do_pop;

   assign push_ready = (count_ff != scl_pkg::QCNT_W'(scl_pkg::QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];

   assign do_push = push_valid && push_ready;
   assign do_pop  = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

### rtl/core/scl_exec.sv
module scl_exec (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  scl_pkg::entry_type pop_entry,
   scl_rsp_if.source          rsp
);

   scl_pkg::state_type            state_ff, state_in;
   logic [scl_pkg::INDEX_W-1:0]   pend_index_ff, pend_index_in;
   logic [scl_pkg::VALUE_W-1:0]   pend_value_ff, pend_value_in;
   logic                          page_ff, page_in;
   logic                          update_ff, update_in;
   logic                          wr, err;
   logic                          is_nibble;

   logic                          out_valid_ff;
   logic                          out_write_ff;
   logic [scl_pkg::INDEX_W-1:0]   out_index_ff;
   logic [scl_pkg::VALUE_W-1:0]   out_value_ff;
   logic                          out_page_ff;
   logic                          out_update_ff;
   logic                          out_error_ff;
   logic                          step;

   // Advance whenever the output register is empty or being drained
   assign pop_ready = !out_valid_ff || rsp.ready;
   assign step      = pop_valid && pop_ready;

   assign is_nibble = (pop_entry.cls == scl_pkg::CL_HEX) || (pop_entry.cls == scl_pkg::CL_DIGIT);

   always_comb begin
      state_in      = scl_pkg::ST_CMD;
      pend_index_in = pend_index_ff;
      pend_value_in = pend_value_ff;
      page_in       = page_ff;
      update_in     = update_ff;
      wr            = 1'b0;
      err           = 1'b0;
      unique case (state_ff)
         scl_pkg::ST_CMD: begin
            case (pop_entry.cls)
               scl_pkg::CL_C: state_in = scl_pkg::ST_REGNUM;
               scl_pkg::CL_P: state_in = scl_pkg::ST_CR_PAGE;
               scl_pkg::CL_D: state_in = scl_pkg::ST_CR_UPD;
               default:       err      = 1'b1;
            endcase
         end
         scl_pkg::ST_REGNUM: begin
            if (pop_entry.cls == scl_pkg::CL_DIGIT) begin
               pend_index_in = pop_entry.index;
               state_in      = scl_pkg::ST_EQUALS;
            end else err = 1'b1;
         end
         scl_pkg::ST_EQUALS: begin
            if (pop_entry.cls == scl_pkg::CL_EQUALS) state_in = scl_pkg::ST_UPPER;
            else err = 1'b1;
         end
         scl_pkg::ST_UPPER: begin
            if (is_nibble) begin
               pend_value_in = {pop_entry.nibble, 4'h0};
               state_in      = scl_pkg::ST_LOWER;
            end else err = 1'b1;
         end
         scl_pkg::ST_LOWER: begin
            if (is_nibble) begin
               pend_value_in = pend_value_ff | {4'h0, pop_entry.nibble};
               state_in      = scl_pkg::ST_CR_REG;
            end else err = 1'b1;
         end
         scl_pkg::ST_CR_REG: begin
            if (pop_entry.cls == scl_pkg::CL_CR) wr = 1'b1;
            else err = 1'b1;
         end
         scl_pkg::ST_CR_PAGE: begin
            if (pop_entry.cls == scl_pkg::CL_CR) page_in = !page_ff;
            else err = 1'b1;
         end
         scl_pkg::ST_CR_UPD: begin
            if (pop_entry.cls == scl_pkg::CL_CR) update_in = !update_ff;
            else err = 1'b1;
         end
         default: begin
            err = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= scl_pkg::ST_CMD;
         pend_index_ff <= '0;
         pend_value_ff <= '0;
         page_ff       <= 1'b0;
         update_ff     <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         if (step) begin
            state_ff      <= state_in;
            pend_index_ff <= pend_index_in;
            pend_value_ff <= pend_value_in;
            page_ff       <= page_in;
            update_ff     <= update_in;
            out_valid_ff  <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff  <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_write_ff  <= wr;
         out_index_ff  <= wr ? pend_index_ff : '0;
         out_value_ff  <= wr ? pend_value_ff : '0;
         out_page_ff   <= page_in;
         out_update_ff <= update_in;
         out_error_ff  <= err;
      end
   end

   assign rsp.valid         = out_valid_ff;
   assign rsp.reg_write     = out_write_ff;
   assign rsp.reg_index     = out_index_ff;
   assign rsp.reg_value     = out_value_ff;
   assign rsp.page_select   = out_page_ff;
   assign rsp.updates_on    = out_update_ff;
   assign rsp.command_error = out_error_ff;

endmodule

### rtl/core/serial_command_line_parser.sv
// Serial command line parser.
// req_ch carries one received character per transaction (char_code); rsp_ch
// returns exactly one result transaction per character, in order: reg_write
// with reg_index/reg_value for a completed "C<d>=<hh>\r", the page and
// display-update flags after the character, and command_error for a character
// that does not fit the command being parsed.
// Path: a character is classified, held in a queue slot, then stepped by the
// state machine into the output register that drives rsp_ch. Throughput: one
// character per cycle while rsp_ch does not stall, set by the state machine
// step in the back end.
// The front end classifies and pushes into a two-entry queue; the back end
// pops when its output register is empty or being taken. While rsp_ch stalls,
// req_ch keeps accepting until the queue is full, then drops ready.
// Synchronous reset empties the queue and output register, returns the parser
// to the command state and clears the pending register and both flags.
module serial_command_line_parser (
   input  logic        clock,
   input  logic        reset,
   scl_req_if.sink     req_ch,
   scl_rsp_if.source   rsp_ch
);

   logic               push_valid, push_ready;
   scl_pkg::entry_type push_entry;
   logic               pop_valid, pop_ready;
   scl_pkg::entry_type pop_entry;

   // Front: classify the character and work out its nibble and index
   scl_classify u_classify (
      .in_valid   (req_ch.valid),
      .in_ready   (req_ch.ready),
      .in_char    (req_ch.char_code),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry)
   );

   // Decouple front and back so either side can stall on its own
   scl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_entry (push_entry),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry)
   );

   // Back: run the command state machine and hold the result transaction
   scl_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_entry  (pop_entry),
      .rsp        (rsp_ch)
   );

endmodule

### tb/sv/tb.sv
module tb;
   import scl_pkg::*;

   // One response transaction as the parser reports it
   typedef struct packed {
      logic               reg_write;
      logic [INDEX_W-1:0] reg_index;
      logic [VALUE_W-1:0] reg_value;
      logic               page_select;
      logic               updates_on;
      logic               command_error;
   } parse_result_type;

   // One entry of the character stream; a pause entry holds the sender back
   // until every expected response has come out
   typedef struct {
      bit                pause;
      logic [CHAR_W-1:0] code;
   } char_item_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   scl_req_if req_ch ();
   scl_rsp_if rsp_ch ();

   serial_command_line_parser uut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   char_item_type    char_q[$];       // characters still to be sent
   parse_result_type expected_q[$];   // responses predicted for accepted characters
   int               chars_queued   = 0;
   int               chars_accepted = 0;
   int               failures       = 0;
   logic             req_taken      = 1'b0;
   logic             calm           = 1'b0;   // final stretch: no new idle bursts on either side
   int               send_gap       = 0;
   int               rsp_stall      = 0;
   parse_result_type got;

   // Parser state as predicted by the testbench
   state_type          parse_state = ST_CMD;
   logic [INDEX_W-1:0] held_index  = '0;
   logic [VALUE_W-1:0] held_value  = '0;
   logic               page_bit    = 1'b0;
   logic               update_bit  = 1'b0;

   function automatic class_type char_class(input logic [CHAR_W-1:0] code);
      if (code == CHAR_EQUALS) return CL_EQUALS;
      if (code == CHAR_CR) return CL_CR;
      if (code == CHAR_C) return CL_C;
      if (code == CHAR_P) return CL_P;
      if (code == CHAR_D) return CL_D;
      if (code > CHAR_ZERO && code < CHAR_COLON) return CL_DIGIT;
      if ((code > CHAR_TICK && code < CHAR_G) || code == CHAR_ZERO) return CL_HEX;
      return CL_OTHER;
   endfunction

   // Hex value of '0'..'9' or 'a'..'f'
   function automatic logic [NIB_W-1:0] hex_nibble(input logic [CHAR_W-1:0] code);
      if (code < CHAR_COLON) return code[NIB_W-1:0];
      return code[NIB_W-1:0] + LETTER_NIBBLE_OFFSET;
   endfunction

   // Advance the predicted parser by one character and return its response
   function automatic parse_result_type parse_char(input logic [CHAR_W-1:0] code);
      class_type        cls;
      state_type        state_after;
      parse_result_type res;
      cls         = char_class(code);
      state_after = ST_CMD;
      res         = '0;
      case (parse_state)
         ST_CMD: begin
            if (cls == CL_C) state_after = ST_REGNUM;
            else if (cls == CL_P) state_after = ST_CR_PAGE;
            else if (cls == CL_D) state_after = ST_CR_UPD;
            else res.command_error = 1'b1;
         end
         ST_REGNUM: begin
            if (cls == CL_DIGIT) begin
               held_index  = code[INDEX_W-1:0] - DIGIT_INDEX_OFFSET;
               state_after = ST_EQUALS;
            end else res.command_error = 1'b1;
         end
         ST_EQUALS: begin
            if (cls == CL_EQUALS) state_after = ST_UPPER;
            else res.command_error = 1'b1;
         end
         ST_UPPER: begin
            if (cls == CL_HEX || cls == CL_DIGIT) begin
               held_value  = {hex_nibble(code), 4'h0};
               state_after = ST_LOWER;
            end else res.command_error = 1'b1;
         end
         ST_LOWER: begin
            if (cls == CL_HEX || cls == CL_DIGIT) begin
               held_value  = held_value | {4'h0, hex_nibble(code)};
               state_after = ST_CR_REG;
            end else res.command_error = 1'b1;
         end
         ST_CR_REG: begin
            if (cls == CL_CR) begin
               res.reg_write = 1'b1;
               res.reg_index = held_index;
               res.reg_value = held_value;
            end else res.command_error = 1'b1;
         end
         ST_CR_PAGE: begin
            if (cls == CL_CR) page_bit = ~page_bit;
            else res.command_error = 1'b1;
         end
         default: begin
            if (cls == CL_CR) update_bit = ~update_bit;
            else res.command_error = 1'b1;
         end
      endcase
      parse_state     = state_after;
      res.page_select = page_bit;
      res.updates_on  = update_bit;
      return res;
   endfunction

   function automatic void check_field(input string field, input int want, input int seen);
      if (want != seen) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, seen);
         failures++;
      end
   endfunction

   task automatic push_byte(input logic [CHAR_W-1:0] code);
      char_item_type item;
      item.pause = 1'b0;
      item.code  = code;
      char_q.push_back(item);
      chars_queued++;
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_byte(s[i]);
   endtask

   task automatic push_pause();
      char_item_type item;
      item.pause = 1'b1;
      item.code  = '0;
      char_q.push_back(item);
   endtask

   // Predict at the accepting edge; the driver learns of the transaction
   // through req_taken at the following falling edge.
   always @(posedge clock) begin
      req_taken <= !reset && req_ch.valid && req_ch.ready;
      calm      <= char_q.size() < 120;
      if (!reset && req_ch.valid && req_ch.ready) begin
         expected_q.push_back(parse_char(req_ch.char_code));
         chars_accepted++;
      end
   end

   // Character driver: hold a presented character until taken, then
   // either idle for a burst, honor a pause, or present the next one.
   always @(negedge clock) begin
      if (reset) begin
         req_ch.valid <= 1'b0;
      end else if (!req_ch.valid || req_taken) begin
         if (send_gap > 0) begin
            send_gap--;
            req_ch.valid <= 1'b0;
         end else if (!calm && $urandom_range(0, 6) == 0) begin
            // this cycle is the first of the burst
            send_gap = $urandom_range(1, 15) - 1;
            req_ch.valid <= 1'b0;
         end else if (char_q.size() != 0 && char_q[0].pause) begin
            // drain: release the pause only once nothing is outstanding
            if (expected_q.size() == 0) void'(char_q.pop_front());
            req_ch.valid <= 1'b0;
         end else if (char_q.size() != 0) begin
            req_ch.char_code <= char_q[0].code;
            req_ch.valid     <= 1'b1;
            void'(char_q.pop_front());
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response ready: stall in random bursts; no new burst starts during the final stretch
   always @(negedge clock) begin
      if (reset) begin
         rsp_ch.ready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_ch.ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
         rsp_stall = $urandom_range(1, 15) - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   // Response monitor: compare each transaction with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         if (expected_q.size() == 0) begin
            $display("%0t: response with none expected, expected none actual write=%0b err=%0b",
                     $time, rsp_ch.reg_write, rsp_ch.command_error);
            failures++;
         end else begin
            got = expected_q.pop_front();
            check_field("reg_write", int'(got.reg_write), int'(rsp_ch.reg_write));
            check_field("reg_index", int'(got.reg_index), int'(rsp_ch.reg_index));
            check_field("reg_value", int'(got.reg_value), int'(rsp_ch.reg_value));
            check_field("page_select", int'(got.page_select), int'(rsp_ch.page_select));
            check_field("updates_on", int'(got.updates_on), int'(rsp_ch.updates_on));
            check_field("command_error", int'(got.command_error),
                        int'(rsp_ch.command_error));
         end
      end
   end

   initial begin
      logic [CHAR_W-1:0] line[6];
      int                len;
      int                kind;
      string             hex_chars;
      hex_chars        = "0123456789abcdef";
      req_ch.valid     = 1'b0;
      req_ch.char_code = '0;
      rsp_ch.ready     = 1'b0;

      // Directed: lowest and highest register with extreme values, both
      // toggles, carriage return with no command, a register digit of zero,
      // uppercase hex, and the extremes of the byte range.
      push_text("C1=00");
      push_byte(CHAR_CR);
      push_text("C9=ff");
      push_byte(CHAR_CR);
      push_byte(CHAR_P);
      push_byte(CHAR_CR);
      push_byte(CHAR_D);
      push_byte(CHAR_CR);
      push_byte(CHAR_CR);
      push_byte(8'hFF);
      push_text("C0");
      push_text("C2=A");
      push_byte(8'h00);
      push_pause();

      // Random: mostly well-formed commands with random content, some
      // corrupted or cut short, plus stray bytes.
      while (chars_queued < 825) begin
         kind = $urandom_range(0, 19);
         if (kind < 11) begin
            line[0] = CHAR_C;
            line[1] = 8'($urandom_range(8'h31, 8'h39));
            line[2] = CHAR_EQUALS;
            line[3] = hex_chars[$urandom_range(0, 15)];
            line[4] = hex_chars[$urandom_range(0, 15)];
            line[5] = CHAR_CR;
            len     = 6;
         end else if (kind < 14) begin
            line[0] = CHAR_P;
            line[1] = CHAR_CR;
            len     = 2;
         end else if (kind < 17) begin
            line[0] = CHAR_D;
            line[1] = CHAR_CR;
            len     = 2;
         end else begin
            line[0] = 8'($urandom_range(0, 255));
            len     = 1;
         end
         if (len > 1 && $urandom_range(0, 4) == 0)
            line[$urandom_range(0, len - 1)] = 8'($urandom_range(0, 255));
         if (len > 1 && $urandom_range(0, 9) == 0)
            len = $urandom_range(1, len - 1);
         for (int i = 0; i < len; i++) push_byte(line[i]);
         if ($urandom_range(0, 149) == 0) push_pause();
      end

      repeat (3) @(negedge clock);
      reset <= 1'b0;

      // Wait for every character to be taken and every response checked
      while (chars_accepted != chars_queued || expected_q.size() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (failures == 0)
         $display("[serial_command_line_parser] OK");
      else
         $display("[serial_command_line_parser] ERROR");
      $finish;
   end

   initial begin
      #400000;
      $display("%0t: timeout", $time);
      $display("[serial_command_line_parser] ERROR");
      $finish;
   end

endmodule
